/* sv/kpsn_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad scan number entry package
// Shared types, constants and the key map used by the scanner, the number
// entry logic and the top level.
// ----------------------------------------------------------------------------
package kpsn_pkg;

   // Number entry storage.
   localparam int MAX_KEYS  = 4;
   localparam int KEY_SLOTS = (MAX_KEYS > 3) ? MAX_KEYS : 3;
   localparam int SLOT_W    = $clog2(KEY_SLOTS);
   localparam int COUNT_W   = $clog2(MAX_KEYS + 1);

   // Field widths.
   localparam int ROWS_W    = 4;
   localparam int COLS_W    = 4;
   localparam int CODE_W    = 4;
   localparam int VALUE_W   = 16;
   localparam int TIMER_W   = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_POLL_TICKS = 2'd1;
   localparam logic [TIMER_W-1:0]     TICKS_RESET            = 8'd10;

   // Values.
   localparam logic [VALUE_W-1:0] NO_KEY_VALUE   = 16'd999;
   localparam logic [VALUE_W-1:0] ASCII_ZERO     = 16'd48;
   localparam logic [CODE_W-1:0]  KEY_ENTER_CODE = 4'd3;

   // Key map, row * 4 + column.
   localparam logic [7:0] KEY_CHARS [16] = '{
      8'h31, 8'h32, 8'h33, 8'h41,
      8'h34, 8'h35, 8'h36, 8'h42,
      8'h37, 8'h38, 8'h39, 8'h43,
      8'h2A, 8'h30, 8'h23, 8'h44
   };

   typedef struct packed {
      logic [TIMER_W-1:0] debounce_ticks;
      logic [TIMER_W-1:0] release_poll_ticks;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } key_event_type;

   typedef struct packed {
      logic               done;
      logic               error;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] setpoint;
   } entry_result_type;

   // Digit term of a key: its character code minus ASCII zero, wrapping.
   function automatic logic [VALUE_W-1:0] digit_term(input logic [CODE_W-1:0] code);
      logic [7:0] ch;
      begin
         ch = KEY_CHARS[code];
         return VALUE_W'(ch) - ASCII_ZERO;
      end
   endfunction

endpackage

/* sv/kpsn_scan.sv */
// ----------------------------------------------------------------------------
// Keypad scanner
// Press detection, debounce, column scan, row decode and release wait.
// Updates once per tick and reports a key when it is released.
// ----------------------------------------------------------------------------
module kpsn_scan
   import kpsn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [ROWS_W-1:0]   rows,
   input  cfg_type             cfg,
   output key_event_type       key_event,
   output logic [COLS_W-1:0]   column_drive
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DEBOUNCE,
      PH_SCAN,
      PH_RELEASE
   } phase_type;

   localparam logic [1:0] COLUMN_LAST = 2'd3;

   phase_type          phase_ff, phase_in;
   logic [1:0]         column_ff, column_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic               found_valid_ff, found_valid_in;
   logic [CODE_W-1:0]  found_code_ff, found_code_in;
   logic               row_onehot;
   logic [1:0]         row_index;

   always_comb begin
      row_onehot = 1'b1;
      row_index  = 2'd0;
      unique case (rows)
         4'b0001: row_index = 2'd0;
         4'b0010: row_index = 2'd1;
         4'b0100: row_index = 2'd2;
         4'b1000: row_index = 2'd3;
         default: row_onehot = 1'b0;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      column_in      = column_ff;
      timer_in       = timer_ff;
      found_valid_in = found_valid_ff;
      found_code_in  = found_code_ff;
      key_event      = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (rows != '0) begin
               phase_in = PH_DEBOUNCE;
               timer_in = cfg.debounce_ticks;
            end
         end
         PH_DEBOUNCE: begin
            if (timer_ff > 8'd1) begin
               timer_in = timer_ff - 8'd1;
            end else if (rows != '0) begin
               phase_in  = PH_SCAN;
               column_in = 2'd0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_SCAN: begin
            if (rows != '0 || column_ff == COLUMN_LAST) begin
               found_valid_in = row_onehot;
               found_code_in  = row_onehot ? {row_index, column_ff} : '0;
               phase_in       = PH_RELEASE;
               timer_in       = cfg.release_poll_ticks;
            end else begin
               column_in = column_ff + 2'd1;
            end
         end
         PH_RELEASE: begin
            if (timer_ff > 8'd1) begin
               timer_in = timer_ff - 8'd1;
            end else if (rows != '0) begin
               timer_in = cfg.release_poll_ticks;
            end else begin
               phase_in        = PH_IDLE;
               key_event.valid = found_valid_ff;
               key_event.code  = found_valid_ff ? found_code_ff : '0;
               found_valid_in  = 1'b0;
               found_code_in   = '0;
            end
         end
      endcase
   end

   assign column_drive = (phase_in == PH_SCAN) ? (COLS_W'(1) << column_in) : '1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         column_ff      <= '0;
         timer_ff       <= '0;
         found_valid_ff <= 1'b0;
         found_code_ff  <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         column_ff      <= column_in;
         timer_ff       <= timer_in;
         found_valid_ff <= found_valid_in;
         found_code_ff  <= found_code_in;
      end
   end

endmodule

/* sv/kpsn_entry.sv */
// ----------------------------------------------------------------------------
// Number entry
// Stores reported keys and parses them into a decimal value on the enter
// key, keeping the last good value as the setpoint.
// ----------------------------------------------------------------------------
module kpsn_entry
   import kpsn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  key_event_type    key_event,
   output entry_result_type result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CODE_W-1:0]  keys_ff [KEY_SLOTS];
   logic [VALUE_W-1:0] setpoint_ff, setpoint_in;
   logic               store;
   logic [VALUE_W-1:0] term0, term1, term2, parsed;

   assign term0 = digit_term(keys_ff[0]);
   assign term1 = digit_term(keys_ff[1]);
   assign term2 = digit_term(keys_ff[2]);

   always_comb begin
      count_in    = count_ff;
      setpoint_in = setpoint_ff;
      store       = 1'b0;
      parsed      = '0;
      result      = '0;
      if (key_event.valid) begin
         if (count_ff >= COUNT_W'(MAX_KEYS)) begin
            result.done  = 1'b1;
            result.error = 1'b1;
         end else if (key_event.code != KEY_ENTER_CODE) begin
            store    = 1'b1;
            count_in = count_ff + COUNT_W'(1);
         end else begin
            result.done = 1'b1;
            priority if (count_ff == 1) begin
               parsed = term0;
            end else if (count_ff == 2) begin
               parsed = VALUE_W'(term0 * 16'd10) + term1;
            end else if (count_ff == 3) begin
               parsed = VALUE_W'(term0 * 16'd100) + VALUE_W'(term1 * 16'd10) + term2;
            end else begin
               result.error = 1'b1;
            end
            if (parsed == NO_KEY_VALUE) begin
               result.error = 1'b1;
            end
            if (!result.error) begin
               result.value = parsed;
               setpoint_in  = parsed;
            end
         end
         if (result.done) begin
            count_in = '0;
            if (result.error) begin
               result.value = NO_KEY_VALUE;
            end
         end
      end
      result.setpoint = setpoint_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         setpoint_ff <= NO_KEY_VALUE;
      end else if (step) begin
         count_ff    <= count_in;
         setpoint_ff <= setpoint_in;
      end
   end

   // Key storage has no reset; entries are read only after being written.
   always_ff @(posedge clock) begin
      if (step && store) begin
         keys_ff[count_ff[SLOT_W-1:0]] <= key_event.code;
      end
   end

endmodule

/* sv/keypad_scan_number_entry.sv */
// ----------------------------------------------------------------------------
// Keypad scan number entry
// 4x4 matrix keypad scanner with decimal number entry and a held setpoint.
// ----------------------------------------------------------------------------
// Each request transfer is one scan tick carrying the row lines sampled under
// the column drive of the previous response (all ones after reset). Every
// request produces exactly one response transfer, and one request can be
// taken in every clock cycle while responses are being taken. A request
// lands in an input register, the scanner and number entry state advance in
// a single pass of logic from that register, and the outcome is captured in
// the response register, which raises response valid. The response register
// decouples the two sides: a new request is taken while a finished response
// still waits, and the pipeline stops only when both the input and response
// registers are full and the response is not taken.
// Timer registers may be written through the CSR channel, which is always
// ready; writes are meant to happen while no tick is in flight. A timer value
// of zero behaves like one.
// ----------------------------------------------------------------------------
module keypad_scan_number_entry
   import kpsn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: row_lines[3:0], zero fill [7:4].
   input  logic [REQ_DATA_W-1:0]  req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: column_drive[3:0], key_valid[4], key_code[8:5],
   // entry_done[9], entry_error[10], entry_value[26:11], setpoint[42:27],
   // zero fill [47:43].
   output logic [RSP_DATA_W-1:0]  rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type             cfg_ff;
   logic                in_valid_ff;
   logic [ROWS_W-1:0]   in_rows_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                step;
   key_event_type       key_event;
   logic [COLS_W-1:0]   column_drive;
   entry_result_type    entry;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= TICKS_RESET;
         cfg_ff.release_poll_ticks <= TICKS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_DEBOUNCE_TICKS) begin
            cfg_ff.debounce_ticks <= csr_wdata;
         end
         if (csr_index == CSR_RELEASE_POLL_TICKS) begin
            cfg_ff.release_poll_ticks <= csr_wdata;
         end
      end
   end

   // A tick is processed when the input register holds one and the response
   // register is empty or being emptied in this cycle.
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_rows_ff <= req_tdata[ROWS_W-1:0];
      end
   end

   kpsn_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rows         (in_rows_ff),
      .cfg          (cfg_ff),
      .key_event    (key_event),
      .column_drive (column_drive)
   );

   kpsn_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .key_event (key_event),
      .result    (entry)
   );

   // Response packing and register.
   assign rsp_data_in = {5'b0, entry.setpoint, entry.value, entry.error, entry.done,
                         key_event.code, key_event.valid, column_drive};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An entry can only finish on the tick that reports a key.
   a_done_needs_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[9] |-> rsp_data_ff[4])
      else $error("entry finished without a reported key");

   // A failed entry always reports the no-key value.
   a_error_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[10] |-> rsp_data_ff[9] && rsp_data_ff[26:11] == NO_KEY_VALUE)
      else $error("entry error without done or with a wrong value");

   // Columns are all driven or exactly one is driven.
   a_column_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[3:0] == 4'hF || $onehot(rsp_data_ff[3:0]))
      else $error("illegal column drive pattern");

endmodule
